// File: sv/wud_pkg.sv
// Shared types and constants of the wide unsigned divider.
`default_nettype none

package wud_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } t_status;

endpackage

`default_nettype wire

// File: sv/wud_if.sv
// Valid/ready channel interfaces for the divider's operand and result transfers.
`default_nettype none

interface wud_in_if #(
    parameter int WORD_BITS = 64
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] dividend_high;
    logic [WORD_BITS-1:0] dividend_low;
    logic [WORD_BITS-1:0] divisor;

    modport source (output valid, output dividend_high, output dividend_low,
                    output divisor, input ready);
    modport sink   (input valid, input dividend_high, input dividend_low,
                    input divisor, output ready);
endinterface

interface wud_out_if #(
    parameter int WORD_BITS = 64
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] quotient;
    logic [WORD_BITS-1:0] remainder;
    wud_pkg::t_status     status;

    modport source (output valid, output quotient, output remainder,
                    output status, input ready);
    modport sink   (input valid, input quotient, input remainder,
                    input status, output ready);
endinterface

`default_nettype wire

// File: sv/wud_check.sv
// Entry stage: classify the operands and seed the division chain.
`default_nettype none

module wud_check #(
    parameter int WORD_BITS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [WORD_BITS-1:0] i_hi,
    input  wire logic [WORD_BITS-1:0] i_lo,
    input  wire logic [WORD_BITS-1:0] i_div,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [WORD_BITS-1:0]      o_rem,
    output logic [WORD_BITS-1:0]      o_lq,
    output logic [WORD_BITS-1:0]      o_div,
    output wud_pkg::t_status          o_status
);

    logic                 r_valid;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_lq;
    logic [WORD_BITS-1:0] r_div;
    wud_pkg::t_status     r_status;

    logic [WORD_BITS-1:0] n_rem;
    logic [WORD_BITS-1:0] n_lq;
    logic [WORD_BITS-1:0] n_div;
    wud_pkg::t_status     n_status;

    assign o_ready = !r_valid || i_ready;

    // A rejected item runs the chain with zero operands and an all-ones
    // divisor, so no step subtracts and the results come out zero.
    always_comb begin
        n_rem    = i_hi;
        n_lq     = i_lo;
        n_div    = i_div;
        n_status = wud_pkg::STATUS_OK;
        if (i_div == '0) begin
            n_status = wud_pkg::STATUS_DIV_ZERO;
        end else if (i_hi >= i_div) begin
            n_status = wud_pkg::STATUS_OVERFLOW;
        end
        if (n_status != wud_pkg::STATUS_OK) begin
            n_rem = '0;
            n_lq  = '0;
            n_div = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rem    <= n_rem;
            r_lq     <= n_lq;
            r_div    <= n_div;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_rem    = r_rem;
    assign o_lq     = r_lq;
    assign o_div    = r_div;
    assign o_status = r_status;

endmodule

`default_nettype wire

// File: sv/wud_cell.sv
// One restoring-division step: shift in a dividend bit, subtract, emit a quotient bit.
`default_nettype none

module wud_cell #(
    parameter int WORD_BITS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [WORD_BITS-1:0] i_rem,
    input  wire logic [WORD_BITS-1:0] i_lq,
    input  wire logic [WORD_BITS-1:0] i_div,
    input  wire wud_pkg::t_status     i_status,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [WORD_BITS-1:0]      o_rem,
    output logic [WORD_BITS-1:0]      o_lq,
    output logic [WORD_BITS-1:0]      o_div,
    output wud_pkg::t_status          o_status
);

    logic                 r_valid;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_lq;
    logic [WORD_BITS-1:0] r_div;
    wud_pkg::t_status     r_status;

    logic [WORD_BITS-1:0] n_rem;
    logic [WORD_BITS-1:0] n_lq;
    logic [WORD_BITS-1:0] shifted;
    logic                 take;

    assign o_ready = !r_valid || i_ready;

    // The low word and the quotient share one register: each step moves the
    // next dividend bit out at the top and the new quotient bit in at the bottom.
    always_comb begin
        shifted = {i_rem[WORD_BITS-2:0], i_lq[WORD_BITS-1]};
        take    = i_rem[WORD_BITS-1] || (shifted >= i_div);
        n_rem   = take ? (shifted - i_div) : shifted;
        n_lq    = {i_lq[WORD_BITS-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rem    <= n_rem;
            r_lq     <= n_lq;
            r_div    <= i_div;
            r_status <= i_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_rem    = r_rem;
    assign o_lq     = r_lq;
    assign o_div    = r_div;
    assign o_status = r_status;

endmodule

`default_nettype wire

// File: sv/wide_unsigned_divider.sv
// Top level of the pipelined double-width by single-width unsigned divider.
`default_nettype none

// Divides the double-width unsigned value {dividend_high, dividend_low} by a
// single-width divisor and returns quotient, remainder and a status code.
// A divisor of zero reports STATUS_DIV_ZERO; a high word at or above the
// divisor (quotient would not fit in one word) reports STATUS_OVERFLOW; both
// return zero quotient and remainder, and a zero divisor wins over overflow.
// The datapath is an entry stage followed by a row of WORD_BITS restoring
// cells, one quotient bit per cell, each cell a register stage with its own
// valid bit. One division is accepted every clock cycle unless the output
// stalls; an input passes the entry stage and then every cell, the last of
// which is the output register. Every stage holds its item and takes a new
// one whenever it is empty or its successor moves, so bubbles close up and
// a result waiting at the output does not stop earlier stages from filling.

module wide_unsigned_divider #(
    parameter int WORD_BITS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wud_in_if.sink    i_in,
    wud_out_if.source o_out
);

    // Stage 0 is the entry stage; stage k (k >= 1) is the k-th cell.
    logic                 w_valid  [0:WORD_BITS];
    logic                 w_ready  [0:WORD_BITS];
    logic [WORD_BITS-1:0] w_rem    [0:WORD_BITS];
    logic [WORD_BITS-1:0] w_lq     [0:WORD_BITS];
    logic [WORD_BITS-1:0] w_div    [0:WORD_BITS];
    wud_pkg::t_status     w_status [0:WORD_BITS];

    // Classify the operands and load the first partial remainder.
    wud_check #(
        .WORD_BITS (WORD_BITS)
    ) u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_hi     (i_in.dividend_high),
        .i_lo     (i_in.dividend_low),
        .i_div    (i_in.divisor),
        .o_valid  (w_valid[0]),
        .i_ready  (w_ready[0]),
        .o_rem    (w_rem[0]),
        .o_lq     (w_lq[0]),
        .o_div    (w_div[0]),
        .o_status (w_status[0])
    );

    // Advance one quotient bit per cell, most significant first.
    for (genvar k = 1; k <= WORD_BITS; k++) begin : g_cell
        wud_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_valid[k-1]),
            .o_ready  (w_ready[k-1]),
            .i_rem    (w_rem[k-1]),
            .i_lq     (w_lq[k-1]),
            .i_div    (w_div[k-1]),
            .i_status (w_status[k-1]),
            .o_valid  (w_valid[k]),
            .i_ready  (w_ready[k]),
            .o_rem    (w_rem[k]),
            .o_lq     (w_lq[k]),
            .o_div    (w_div[k]),
            .o_status (w_status[k])
        );
    end

    // The last cell's register is the output register: after all steps the
    // shared low-word register holds the full quotient.
    assign w_ready[WORD_BITS] = o_out.ready;
    assign o_out.valid        = w_valid[WORD_BITS];
    assign o_out.quotient     = w_lq[WORD_BITS];
    assign o_out.remainder    = w_rem[WORD_BITS];
    assign o_out.status       = w_status[WORD_BITS];

endmodule

`default_nettype wire
